### src/aestk_pkg.sv
`timescale 1ns / 1ps

package aestk_pkg;

   // word and field widths
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned CMD_W       = 3;
   localparam int unsigned POS_W       = 10;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned FILL_W      = 11;

   // default stack depth
   localparam int unsigned STACK_DEPTH = 1024;

   // stream payload widths
   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned REQ_TUSER_W = CMD_W;
   localparam int unsigned REQ_PAD_W   = REQ_TDATA_W - DATA_W - POS_W;
   localparam int unsigned RSP_TDATA_W = 48;
   localparam int unsigned RSP_PAD_W   = RSP_TDATA_W - DATA_W - STATUS_W - FILL_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH        = 3'd0,
      CMD_POP         = 3'd1,
      CMD_PEEK_TOP    = 3'd2,
      CMD_PEEK_BOTTOM = 3'd3,
      CMD_ADD         = 3'd4,
      CMD_SUB         = 3'd5,
      CMD_MUL         = 3'd6,
      CMD_DIV         = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_FEW     = 3'd1,
      STAT_RANGE   = 3'd2,
      STAT_DIVZERO = 3'd3,
      STAT_FULL    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_RD_TOP,
      S_RD_UNDER,
      S_DIV,
      S_WB,
      S_RESP
   } state_type;

   // divider handshake with the sequencer
   typedef struct packed {
      logic                    done;
      logic signed [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

### src/aestk_ram.sv
`timescale 1ns / 1ps

module aestk_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### src/aestk_div.sv
`timescale 1ns / 1ps

module aestk_div (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [aestk_pkg::DATA_W-1:0]     dividend,
   input  logic signed [aestk_pkg::DATA_W-1:0]     divisor,
   output aestk_pkg::div_rsp_type                  div_rsp
);

   import aestk_pkg::*;

   localparam int unsigned CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;
   logic [DATA_W-1:0] dividend_mag;
   logic [DATA_W-1:0] divisor_mag;

   // magnitudes fit unsigned, including the most negative word
   assign dividend_mag = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
   assign divisor_mag  = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;

   // one restoring step per cycle
   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend_mag;
         den_in  = divisor_mag;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
         end else begin
            rem_in = shifted[DATA_W-1:0];
         end
         quo_in = {quo_ff[DATA_W-2:0], ~diff[DATA_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // floored sign fix: -q, minus one more when a remainder is left
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (~quo_ff + DATA_W'(rem_ff == '0)) : quo_ff;

endmodule

### src/arithmetic_evaluation_stack.sv
`timescale 1ns / 1ps

// Evaluation stack of signed 32-bit words in a single-port synchronous RAM. Each request
// carries a command in req_tuser: push, pop, peek by depth from the top, peek by position from
// the bottom, or add, subtract, multiply or floored divide of the two top entries (under-top
// op top, wrapping at 32 bits), which replace them with the result. Every request returns one
// response with the word (zero on push and on any error), a status and the fill count after
// the command; a failing command leaves the stack as it was. The stack's only port is the RAM
// port, so commands run in steps from accept to response loaded: push and the errors found at
// accept go straight to the response, pop and peek make one RAM read, add, subtract and multiply
// two reads and a write-back, divide by zero both reads and no write-back, divide both reads,
// the radix-2 divider's 32 steps, quotient hand-over and write-back. The next request is
// taken the cycle after the response is loaded into the output register, even while that
// response waits on rsp_tready; it is only held back while the previous one is still unaccepted.
module arithmetic_evaluation_stack #(
   parameter int unsigned DEPTH = aestk_pkg::STACK_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] push_value, [41:32] position, [47:42] zero
   input  logic [aestk_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [2:0] cmd
   input  logic [aestk_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] result_value, [34:32] status, [45:35] fill_count, [47:46] zero
   output logic [aestk_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   import aestk_pkg::*;

   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   // state and request holding registers
   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [DATA_W-1:0]       top_ff, top_in;
   logic [DATA_W-1:0]       res_ff, res_in;
   status_type              st_ff, st_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // ram port
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_addr;
   logic [DATA_W-1:0]       ram_wdata;
   logic [DATA_W-1:0]       ram_rdata;

   // divider
   logic                    div_start;
   div_rsp_type             div_rsp;

   // request fields
   cmd_type                 req_cmd;
   logic [DATA_W-1:0]       req_value;
   logic [POS_W-1:0]        req_pos;

   assign req_cmd   = cmd_type'(req_tuser[CMD_W-1:0]);
   assign req_value = req_tdata[DATA_W-1:0];
   assign req_pos   = req_tdata[DATA_W +: POS_W];

   aestk_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   aestk_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ram_rdata),
      .divisor  (top_ff),
      .div_rsp  (div_rsp)
   );

   // request taken only while the sequencer is idle
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      res_in       = res_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_addr     = ADDR_W'(count_ff);
      ram_wdata    = req_value;
      div_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_cmd;
               res_in   = '0;
               st_in    = STAT_OK;
               state_in = S_RESP;
               case (req_cmd)
                  CMD_PUSH: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        st_in = STAT_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        ram_addr = ADDR_W'(count_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        st_in = STAT_FEW;
                     end else begin
                        ram_addr = ADDR_W'(count_ff - 1'b1);
                        count_in = count_ff - 1'b1;
                        state_in = S_READ;
                     end
                  end
                  CMD_PEEK_TOP: begin
                     if (CMP_W'(req_pos) >= CMP_W'(count_ff)) begin
                        st_in = STAT_RANGE;
                     end else begin
                        // position is below the count here, so it fits the count width
                        ram_addr = ADDR_W'(count_ff - 1'b1 - CNT_W'(req_pos));
                        state_in = S_READ;
                     end
                  end
                  CMD_PEEK_BOTTOM: begin
                     if (CMP_W'(req_pos) >= CMP_W'(count_ff)) begin
                        st_in = STAT_RANGE;
                     end else begin
                        ram_addr = ADDR_W'(req_pos);
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     // arithmetic: needs two entries, top read first
                     if (count_ff < CNT_W'(2)) begin
                        st_in = STAT_FEW;
                     end else begin
                        ram_addr = ADDR_W'(count_ff - 1'b1);
                        state_in = S_RD_TOP;
                     end
                  end
               endcase
            end
         end

         S_READ: begin
            res_in   = ram_rdata;
            state_in = S_RESP;
         end

         S_RD_TOP: begin
            top_in   = ram_rdata;
            ram_addr = ADDR_W'(count_ff - CNT_W'(2));
            state_in = S_RD_UNDER;
         end

         S_RD_UNDER: begin
            // ram_rdata holds the under-top entry now
            case (cmd_ff)
               CMD_ADD: begin
                  res_in   = ram_rdata + top_ff;
                  state_in = S_WB;
               end
               CMD_SUB: begin
                  res_in   = ram_rdata - top_ff;
                  state_in = S_WB;
               end
               CMD_MUL: begin
                  res_in   = ram_rdata * top_ff;
                  state_in = S_WB;
               end
               default: begin
                  if (top_ff == '0) begin
                     st_in    = STAT_DIVZERO;
                     state_in = S_RESP;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
            endcase
         end

         S_DIV: begin
            if (div_rsp.done) begin
               res_in   = div_rsp.quotient;
               state_in = S_WB;
            end
         end

         S_WB: begin
            // result replaces the two top entries
            ram_we    = 1'b1;
            ram_addr  = ADDR_W'(count_ff - CNT_W'(2));
            ram_wdata = res_ff;
            count_in  = count_ff - 1'b1;
            state_in  = S_RESP;
         end

         S_RESP: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, FILL_W'(count_ff), st_ff, res_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      top_ff      <= top_in;
      res_ff      <= res_in;
      st_ff       <= st_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
